>>> rtl/core/chull_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_pkg
// Shared types and fixed constants of the convex hull unit.
// ----------------------------------------------------------------------------
package chull_pkg;

	localparam int COORD_W = 20;              // coordinate width, 4 fraction bits
	localparam int DIFF_W  = COORD_W + 1;     // exact coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;      // exact cross product term
	localparam int MAX_OUT = 8;               // most hull vertices given per batch
	localparam int CNT_W   = 4;               // holds 0 .. MAX_OUT

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

endpackage

>>> rtl/core/convex_hull_of_eight_points_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_of_eight_points_unit
// Monotone chain convex hull of a batch of POINT_COUNT fixed point points.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall, point_x / point_y) takes one point
//   per item. Each point is insertion-sorted into the point registers by
//   (x, y) with one comparator, one entry per cycle, and the input stalls
//   while the item is sorted in. After the last point of a batch the hull
//   is built with one shared 21 x 21 multiplier: every turn test runs two
//   operand fetches, two products and one compare, a pop one more check and
//   every point of the two chains a fetch, a check and a push.
//   The hull vertices (at most 8) then leave on the output channel
//   (out_valid / out_stall, hull_x / hull_y / hull_last) counter-clockwise
//   from the smallest (x, y) point, one per cycle when not stalled; the last
//   one carries hull_last. A stall simply holds the output register and the
//   walk through the hull stack. The next batch is accepted as soon as the
//   last vertex sits in the output register.
//   Reset (arst_n low) empties the batch, drops any output and returns the
//   sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module convex_hull_of_eight_points_unit
	import chull_pkg::*;
#(
	parameter int POINT_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] hull_x,
	output logic [COORD_W-1:0] hull_y,
	output logic               hull_last
);

	localparam int IW  = $clog2(POINT_COUNT);   // point index
	localparam int SD  = POINT_COUNT + 1;       // hull stack entries
	localparam int SAW = $clog2(SD);            // hull stack index
	localparam int DW  = $clog2(SD + 1);        // hull stack fill

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS     = 4'd1;
	localparam logic [3:0] S_FETCH_C = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_FA      = 4'd4;
	localparam logic [3:0] S_FB      = 4'd5;
	localparam logic [3:0] S_MUL1    = 4'd6;
	localparam logic [3:0] S_MUL2    = 4'd7;
	localparam logic [3:0] S_CMP     = 4'd8;
	localparam logic [3:0] S_PUSH    = 4'd9;
	localparam logic [3:0] S_EMIT    = 4'd10;

	logic [3:0]    state_q;
	point_t        pts_q [POINT_COUNT];
	logic [IW-1:0] stack_q [SD];
	logic [IW-1:0] loaded_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] i_q;
	point_t        new_q;
	point_t        c_q;
	point_t        a_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] floor_q;
	logic          upper_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] k_q;

	logic signed [DIFF_W-1:0] dbx_q, dby_q, dcx_q, dcy_q;
	logic signed [PROD_W-1:0] p1_q, p2_q;

	logic               out_valid_q;
	logic [COORD_W-1:0] hull_x_q, hull_y_q;
	logic               hull_last_q;

	logic [DW-1:0]  depth_m1, depth_m2, k_ext;
	logic [SAW-1:0] sidx;
	logic [IW-1:0]  rd_addr;
	point_t         rd_pt;
	logic           new_before;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic           emit_load, emit_last;
	logic           pop_ok;

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign k_ext    = DW'(k_q);

	// single read port into the hull stack
	always_comb begin
		case (state_q)
			S_FA:    sidx = depth_m2[SAW-1:0];
			S_FB:    sidx = depth_m1[SAW-1:0];
			default: sidx = k_ext[SAW-1:0];
		endcase
	end

	// single read port into the sorted points
	always_comb begin
		case (state_q)
			S_INS:     rd_addr = j_q - IW'(1);
			S_FETCH_C: rd_addr = i_q;
			S_FA:      rd_addr = stack_q[sidx];
			S_FB:      rd_addr = stack_q[sidx];
			S_EMIT:    rd_addr = stack_q[sidx];
			default:   rd_addr = i_q;
		endcase
	end

	assign rd_pt = pts_q[rd_addr];

	assign new_before = ($signed(new_q.x) < $signed(rd_pt.x)) ||
		((new_q.x == rd_pt.x) && ($signed(new_q.y) < $signed(rd_pt.y)));

	// shared multiplier for both cross product terms
	assign mul_a = (state_q == S_MUL1) ? dbx_q : dby_q;
	assign mul_b = (state_q == S_MUL1) ? dcy_q : dcx_q;
	assign mul_p = mul_a * mul_b;

	assign pop_ok    = (depth_q >= floor_q) && (depth_q >= DW'(2));
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = ((k_q + CNT_W'(1)) == cnt_q);

	// point and stack storage, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_INS) begin
			if (j_q != '0 && new_before)
				pts_q[j_q] <= rd_pt;
			else
				pts_q[j_q] <= new_q;
		end
		if (state_q == S_PUSH && depth_q < DW'(SD))
			stack_q[depth_q[SAW-1:0]] <= i_q;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			new_q.x <= point_x;
			new_q.y <= point_y;
		end
		if (state_q == S_FETCH_C)
			c_q <= rd_pt;
		if (state_q == S_FA)
			a_q <= rd_pt;
		if (state_q == S_FB) begin
			dbx_q <= DIFF_W'($signed(rd_pt.x)) - DIFF_W'($signed(a_q.x));
			dby_q <= DIFF_W'($signed(rd_pt.y)) - DIFF_W'($signed(a_q.y));
			dcx_q <= DIFF_W'($signed(c_q.x)) - DIFF_W'($signed(a_q.x));
			dcy_q <= DIFF_W'($signed(c_q.y)) - DIFF_W'($signed(a_q.y));
		end
		if (state_q == S_MUL1)
			p1_q <= mul_p;
		if (state_q == S_MUL2)
			p2_q <= mul_p;
		if (emit_load) begin
			hull_x_q    <= rd_pt.x;
			hull_y_q    <= rd_pt.y;
			hull_last_q <= emit_last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			j_q         <= '0;
			i_q         <= '0;
			depth_q     <= '0;
			floor_q     <= '0;
			upper_q     <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						j_q     <= loaded_q;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (j_q != '0 && new_before) begin
						j_q <= j_q - IW'(1);
					end else if (loaded_q == IW'(POINT_COUNT - 1)) begin
						loaded_q <= '0;
						i_q      <= '0;
						depth_q  <= '0;
						floor_q  <= DW'(2);
						upper_q  <= 1'b0;
						state_q  <= S_FETCH_C;
					end else begin
						loaded_q <= loaded_q + IW'(1);
						state_q  <= S_IDLE;
					end
				end
				S_FETCH_C: state_q <= S_CHECK;
				S_CHECK:   state_q <= pop_ok ? S_FA : S_PUSH;
				S_FA:      state_q <= S_FB;
				S_FB:      state_q <= S_MUL1;
				S_MUL1:    state_q <= S_MUL2;
				S_MUL2:    state_q <= S_CMP;
				S_CMP: begin
					if (p1_q > p2_q) begin
						state_q <= S_PUSH;
					end else begin
						depth_q <= depth_m1;
						state_q <= S_CHECK;
					end
				end
				S_PUSH: begin
					if (!upper_q) begin
						depth_q <= depth_q + DW'(1);
						if (i_q == IW'(POINT_COUNT - 1)) begin
							// lower hull done, upper hull starts from the last point
							upper_q <= 1'b1;
							floor_q <= depth_q + DW'(2);
						end else begin
							i_q <= i_q + IW'(1);
						end
						state_q <= S_FETCH_C;
					end else if (i_q == '0) begin
						// closing push repeats the first point and is dropped
						if (int'(depth_q) > MAX_OUT)
							cnt_q <= CNT_W'(MAX_OUT);
						else
							cnt_q <= CNT_W'(depth_q);
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						depth_q <= depth_q + DW'(1);
						i_q     <= i_q - IW'(1);
						state_q <= S_FETCH_C;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						if (emit_last)
							state_q <= S_IDLE;
						else
							k_q <= k_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign hull_x    = hull_x_q;
	assign hull_y    = hull_y_q;
	assign hull_last = hull_last_q;

`ifndef SYNTHESIS
	// hull stack never overflows
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(SD))
		else $error("hull stack depth out of range");

	// batch fill count stays below the batch size
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= IW'(POINT_COUNT - 1))
		else $error("batch count out of range");

	// a lower hull push always leaves at least one entry on the stack
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && !upper_q) |=> depth_q != '0)
		else $error("stack empty after push");

	// the vertex count is sane while emitting
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> (cnt_q != '0 && int'(cnt_q) <= MAX_OUT && k_q < cnt_q))
		else $error("bad vertex count");

	// loading the last vertex marks it and frees the input side
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> (state_q == S_IDLE && out_valid && hull_last))
		else $error("last vertex not marked");
`endif

endmodule
